[rtl/binary_fluid_lbm_equilibrium_assert.svh]
// Assertion macros shared by the RTL; clk and rst must be in scope.
`ifndef BINARY_FLUID_LBM_EQUILIBRIUM_ASSERT_SVH
`define BINARY_FLUID_LBM_EQUILIBRIUM_ASSERT_SVH

// same-cycle implication
`define BFLBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFLBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bflbm_pkg.sv]
package bflbm_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int CFG_INDEX_W = 2;

  typedef logic signed [31:0] q_t;
  typedef logic [3:0] dir_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = -32'sh7FFF_FFFF - 32'sh1;

  localparam longint Q_ONE = longint'(1) << FRAC_BITS;

  localparam q_t K_1_12 = q_t'((Q_ONE + 6) / 12);
  localparam q_t K_1_6  = q_t'((Q_ONE + 3) / 6);
  localparam q_t K_1_3  = q_t'((Q_ONE + 1) / 3);
  localparam q_t K_1_9  = q_t'((Q_ONE + 4) / 9);
  localparam q_t K_4_9  = q_t'((4 * Q_ONE + 4) / 9);
  localparam q_t K_1_36 = q_t'((Q_ONE + 18) / 36);
  localparam q_t K_1_2  = q_t'((Q_ONE + 1) / 2);
  localparam q_t K_3_4  = q_t'((3 * Q_ONE + 2) / 4);
  localparam q_t K_3_2  = q_t'((3 * Q_ONE + 1) / 2);
  localparam q_t K_9_4  = q_t'((9 * Q_ONE + 2) / 4);
  localparam q_t K_9_2  = q_t'((9 * Q_ONE + 1) / 2);

  localparam q_t COEFF_A_RESET = q_t'(-((Q_ONE + 5) / 10));
  localparam q_t COEFF_B_RESET = q_t'((Q_ONE + 5) / 10);
  localparam q_t KAPPA_RESET   = q_t'((9 * Q_ONE + 50) / 100);

  localparam dir_t DIR_EAST  = 4'd0;
  localparam dir_t DIR_NORTH = 4'd1;
  localparam dir_t DIR_WEST  = 4'd2;
  localparam dir_t DIR_SOUTH = 4'd3;
  localparam dir_t DIR_NE    = 4'd4;
  localparam dir_t DIR_NW    = 4'd5;
  localparam dir_t DIR_SW    = 4'd6;
  localparam dir_t DIR_SE    = 4'd7;
  localparam dir_t DIR_REST  = 4'd8;

  // per-field node context handed from front to back
  typedef struct packed {
    q_t m;
    q_t mx;
    q_t my;
    q_t sxx;
    q_t syy;
    q_t dp;
    q_t dm;
    q_t u15;
  } fld_t;

  typedef struct packed {
    fld_t phi;
    fld_t rho;
  } node_t;

  function automatic q_t sat(input logic signed [63:0] v);
    if (v > 64'(Q_MAX)) return Q_MAX;
    if (v < 64'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat(64'(a) + 64'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat(64'(a) - 64'(b));
  endfunction

  function automatic q_t qneg(input q_t a);
    return sat(-64'(a));
  endfunction

  function automatic q_t qimul(input q_t a, input logic signed [3:0] k);
    return sat(64'(a) * 64'(k));
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
    return sat(p >>> FRAC_BITS);
  endfunction

endpackage

[rtl/bflbm_if.sv]
interface bflbm_node_if;
  import bflbm_pkg::*;

  logic valid;
  logic ready;
  q_t   phi_center;
  q_t   phi_north;
  q_t   phi_south;
  q_t   phi_east;
  q_t   phi_west;
  q_t   phi_northeast;
  q_t   phi_northwest;
  q_t   phi_southwest;
  q_t   phi_southeast;
  q_t   density;
  q_t   velocity_x;
  q_t   velocity_y;

  modport source (
    output valid, phi_center, phi_north, phi_south, phi_east, phi_west,
    output phi_northeast, phi_northwest, phi_southwest, phi_southeast,
    output density, velocity_x, velocity_y,
    input  ready
  );
  modport sink (
    input  valid, phi_center, phi_north, phi_south, phi_east, phi_west,
    input  phi_northeast, phi_northwest, phi_southwest, phi_southeast,
    input  density, velocity_x, velocity_y,
    output ready
  );
endinterface

interface bflbm_result_if;
  import bflbm_pkg::*;

  logic valid;
  logic ready;
  dir_t direction;
  q_t   eq_order_param;
  q_t   eq_density;
  logic last_of_node;

  modport source (
    output valid, direction, eq_order_param, eq_density, last_of_node,
    input  ready
  );
  modport sink (
    input  valid, direction, eq_order_param, eq_density, last_of_node,
    output ready
  );
endinterface

[rtl/binary_fluid_lbm_equilibrium.sv]
// Channel   Dir  Handshake     Payload
// node      in   valid/ready   phi 3x3 neighborhood, density, velocity_x/y
// result    out  valid/ready   direction, eq_order_param, eq_density, last_of_node
// cfg       in   cfg_write     cfg_index (0 a, 1 b, 2 kappa), cfg_data
//
// One node yields nine results, one per cycle while results are taken, as set by
// the direction sequencer that feeds the back lanes one direction per unstalled cycle.
// The first result is valid once the request has passed through the 9 front
// stages, the queue register and the 4 back stages (B1 to B4). The front
// takes a node every cycle until it and the queue fill; a stalled result holds
// the back, which holds the queue. Synchronous reset clears pipeline valids,
// queue pointers and loads default coefficients.
module binary_fluid_lbm_equilibrium (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bflbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data,
  bflbm_node_if.sink                          node,
  bflbm_result_if.source                      result
);
  import bflbm_pkg::*;

  logic  f_valid, f_ready;
  node_t f_data;
  logic  b_valid, b_ready;
  node_t b_data;

  bflbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .node      (node),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_data    (f_data)
  );

  bflbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  bflbm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .result  (result)
  );

endmodule

[rtl/bflbm_front.sv]
module bflbm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bflbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data,
  bflbm_node_if.sink                          node,
  output logic                                q_valid,
  input  logic                                q_ready,
  output bflbm_pkg::node_t                    q_data
);
  import bflbm_pkg::*;

  localparam int STAGES = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEFF_A       = 2'd0,
    REG_COEFF_B       = 2'd1,
    REG_SURFACE_KAPPA = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    q_t c, r, ux, uy;
    q_t gxs, gys, laps, p2;
    q_t gx, gy, lap, p4, ap2, p2c, ac, rk3;
    q_t cmx, cmy, rmx, rmy;
    q_t gx2, gy2, clap, kgx, kgy, klap, bp4, bp2c, hap2;
    q_t cxx, cyy, cxy, rxx, ryy, rxy;
    q_t pxxg, pyyg, pxy, hg, p34, tmu;
    q_t pk, mu, pi0, pxy2;
    q_t pi, csxx, csyy, csxy, rsxy;
    q_t rsxx, rsyy, cusq, cdp, cdm;
    q_t rusq, rdp, rdm, cu15;
    q_t ru15;
  } work_t;

  q_t    coeff_a;
  q_t    coeff_b;
  q_t    surface_kappa;
  work_t st [1:STAGES];
  work_t nx [1:STAGES];
  logic  vld [1:STAGES];
  logic  adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a       <= COEFF_A_RESET;
      coeff_b       <= COEFF_B_RESET;
      surface_kappa <= KAPPA_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEFF_A:       coeff_a       <= cfg_data;
        REG_COEFF_B:       coeff_b       <= cfg_data;
        REG_SURFACE_KAPPA: surface_kappa <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv        = !vld[STAGES] || q_ready;
  assign node.ready = adv;

  always_comb begin
    // gradient / laplacian stencil sums, phi^2
    nx[1]      = '0;
    nx[1].c    = node.phi_center;
    nx[1].r    = node.density;
    nx[1].ux   = node.velocity_x;
    nx[1].uy   = node.velocity_y;
    nx[1].gxs  = qadd(qadd(qsub(qsub(node.phi_northeast, node.phi_southwest),
                                node.phi_northwest), node.phi_southeast),
                      qimul(qsub(node.phi_east, node.phi_west), 4'sd4));
    nx[1].gys  = qadd(qsub(qadd(qsub(node.phi_northeast, node.phi_southwest),
                                node.phi_northwest), node.phi_southeast),
                      qimul(qsub(node.phi_north, node.phi_south), 4'sd4));
    nx[1].laps = qadd(qadd(qadd(qadd(node.phi_southwest, node.phi_northeast),
                                node.phi_northwest), node.phi_southeast),
                      qimul(qsub(qadd(qadd(qadd(node.phi_south, node.phi_north),
                                           node.phi_west), node.phi_east),
                                 qimul(node.phi_center, 4'sd5)), 4'sd4));
    nx[1].p2   = qmul(node.phi_center, node.phi_center);

    nx[2]      = st[1];
    nx[2].gx   = qmul(K_1_12, st[1].gxs);
    nx[2].gy   = qmul(K_1_12, st[1].gys);
    nx[2].lap  = qmul(K_1_6, st[1].laps);
    nx[2].p4   = qmul(st[1].p2, st[1].p2);
    nx[2].ap2  = qmul(coeff_a, st[1].p2);
    nx[2].p2c  = qmul(st[1].p2, st[1].c);
    nx[2].ac   = qmul(coeff_a, st[1].c);
    nx[2].rk3  = qmul(st[1].r, K_1_3);
    nx[2].cmx  = qmul(st[1].c, st[1].ux);
    nx[2].cmy  = qmul(st[1].c, st[1].uy);
    nx[2].rmx  = qmul(st[1].r, st[1].ux);
    nx[2].rmy  = qmul(st[1].r, st[1].uy);

    nx[3]      = st[2];
    nx[3].gx2  = qmul(st[2].gx, st[2].gx);
    nx[3].gy2  = qmul(st[2].gy, st[2].gy);
    nx[3].clap = qmul(st[2].c, st[2].lap);
    nx[3].kgx  = qmul(surface_kappa, st[2].gx);
    nx[3].kgy  = qmul(surface_kappa, st[2].gy);
    nx[3].klap = qmul(surface_kappa, st[2].lap);
    nx[3].bp4  = qmul(coeff_b, st[2].p4);
    nx[3].bp2c = qmul(coeff_b, st[2].p2c);
    nx[3].hap2 = qmul(K_1_2, st[2].ap2);
    nx[3].cxx  = qmul(st[2].cmx, st[2].ux);
    nx[3].cyy  = qmul(st[2].cmy, st[2].uy);
    nx[3].cxy  = qmul(st[2].cmx, st[2].uy);
    nx[3].rxx  = qmul(st[2].rmx, st[2].ux);
    nx[3].ryy  = qmul(st[2].rmy, st[2].uy);
    nx[3].rxy  = qmul(st[2].rmx, st[2].uy);

    nx[4]      = st[3];
    nx[4].pxxg = qmul(st[3].kgx, st[3].gx);
    nx[4].pyyg = qmul(st[3].kgy, st[3].gy);
    nx[4].pxy  = qmul(st[3].kgx, st[3].gy);
    nx[4].hg   = qmul(K_1_2, qadd(st[3].gx2, st[3].gy2));
    nx[4].p34  = qmul(K_3_4, st[3].bp4);
    nx[4].tmu  = qsub(qadd(st[3].ac, st[3].bp2c), st[3].klap);

    nx[5]      = st[4];
    nx[5].pk   = qmul(surface_kappa, qadd(st[4].clap, st[4].hg));
    nx[5].mu   = qmul(st[4].r, st[4].tmu);
    nx[5].pi0  = qadd(st[4].hap2, st[4].p34);
    nx[5].pxy2 = qimul(st[4].pxy, 4'sd2);

    nx[6]      = st[5];
    nx[6].pi   = qadd(qsub(st[5].pi0, st[5].pk), st[5].rk3);
    nx[6].csxx = qadd(st[5].cxx, st[5].mu);
    nx[6].csyy = qadd(st[5].cyy, st[5].mu);
    nx[6].csxy = qimul(st[5].cxy, 4'sd2);
    nx[6].rsxy = qadd(qimul(st[5].rxy, 4'sd2), st[5].pxy2);

    nx[7]      = st[6];
    nx[7].rsxx = qadd(st[6].rxx, qadd(st[6].pi, st[6].pxxg));
    nx[7].rsyy = qadd(st[6].ryy, qadd(st[6].pi, st[6].pyyg));
    nx[7].cusq = qadd(st[6].csxx, st[6].csyy);
    nx[7].cdp  = qadd(qadd(st[6].csxx, st[6].csxy), st[6].csyy);
    nx[7].cdm  = qadd(qsub(st[6].csxx, st[6].csxy), st[6].csyy);

    nx[8]      = st[7];
    nx[8].rusq = qadd(st[7].rsxx, st[7].rsyy);
    nx[8].rdp  = qadd(qadd(st[7].rsxx, st[7].rsxy), st[7].rsyy);
    nx[8].rdm  = qadd(qsub(st[7].rsxx, st[7].rsxy), st[7].rsyy);
    nx[8].cu15 = qmul(K_3_2, st[7].cusq);

    nx[9]      = st[8];
    nx[9].ru15 = qmul(K_3_2, st[8].rusq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STAGES; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[1] <= node.valid;
      for (int k = 2; k <= STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= STAGES; k++) st[k] <= nx[k];
    end
  end

  assign q_valid = vld[STAGES];

  always_comb begin
    q_data.phi.m   = st[STAGES].c;
    q_data.phi.mx  = st[STAGES].cmx;
    q_data.phi.my  = st[STAGES].cmy;
    q_data.phi.sxx = st[STAGES].csxx;
    q_data.phi.syy = st[STAGES].csyy;
    q_data.phi.dp  = st[STAGES].cdp;
    q_data.phi.dm  = st[STAGES].cdm;
    q_data.phi.u15 = st[STAGES].cu15;
    q_data.rho.m   = st[STAGES].r;
    q_data.rho.mx  = st[STAGES].rmx;
    q_data.rho.my  = st[STAGES].rmy;
    q_data.rho.sxx = st[STAGES].rsxx;
    q_data.rho.syy = st[STAGES].rsyy;
    q_data.rho.dp  = st[STAGES].rdp;
    q_data.rho.dm  = st[STAGES].rdm;
    q_data.rho.u15 = st[STAGES].ru15;
  end

endmodule

[rtl/bflbm_queue.sv]
`include "binary_fluid_lbm_equilibrium_assert.svh"

module bflbm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  bflbm_pkg::node_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bflbm_pkg::node_t  pop_data
);
  import bflbm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  node_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  `BFLBM_ASSERT_IMPL(a_queue_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

[rtl/bflbm_back.sv]
`include "binary_fluid_lbm_equilibrium_assert.svh"

module bflbm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  bflbm_pkg::node_t  q_data,
  bflbm_result_if.source    result
);
  import bflbm_pkg::*;

  localparam int LANES = 2;   // 0 order parameter, 1 density

  fld_t lane [LANES];
  dir_t dir_cnt;
  logic adv;
  logic issue;

  // B1 select, B2 scale terms, B3 combine, B4 weight (output register)
  logic b1_v, b2_v, b3_v, b4_v;
  dir_t b1_dir, b2_dir, b3_dir, b4_dir;
  q_t   b1_x [LANES];
  q_t   b1_s [LANES];
  q_t   b1_u [LANES];
  q_t   b2_a [LANES];
  q_t   b2_b [LANES];
  q_t   b2_u [LANES];
  q_t   b3_t [LANES];
  q_t   b4_y [LANES];

  q_t   sel_x [LANES];
  q_t   sel_s [LANES];
  q_t   prod  [LANES];
  q_t   scale;

  assign lane[0] = q_data.phi;
  assign lane[1] = q_data.rho;

  assign adv     = !b4_v || result.ready;
  assign issue   = q_valid && adv;
  assign q_ready = adv && dir_cnt == DIR_REST;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (dir_cnt)
        DIR_EAST:  begin sel_x[l] = lane[l].mx; sel_s[l] = lane[l].sxx; end
        DIR_NORTH: begin sel_x[l] = lane[l].my; sel_s[l] = lane[l].syy; end
        DIR_WEST:  begin sel_x[l] = qneg(lane[l].mx); sel_s[l] = lane[l].sxx; end
        DIR_SOUTH: begin sel_x[l] = qneg(lane[l].my); sel_s[l] = lane[l].syy; end
        DIR_NE: begin
          sel_x[l] = qadd(lane[l].mx, lane[l].my);
          sel_s[l] = lane[l].dp;
        end
        DIR_NW: begin
          sel_x[l] = qsub(lane[l].my, lane[l].mx);
          sel_s[l] = lane[l].dm;
        end
        DIR_SW: begin
          sel_x[l] = qsub(qneg(lane[l].mx), lane[l].my);
          sel_s[l] = lane[l].dp;
        end
        DIR_SE: begin
          sel_x[l] = qsub(lane[l].mx, lane[l].my);
          sel_s[l] = lane[l].dm;
        end
        default: begin sel_x[l] = lane[l].m; sel_s[l] = '0; end
      endcase
    end
  end

  // rest direction: 9/4*m in place of 3*v, no 9/2*s term
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod[l] = (b1_dir == DIR_REST) ? qmul(K_9_4, b1_x[l]) : qmul(K_9_2, b1_s[l]);
    end
  end

  always_comb begin
    if (b3_dir < DIR_NE)        scale = K_1_9;
    else if (b3_dir < DIR_REST) scale = K_1_36;
    else                        scale = K_4_9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_cnt <= DIR_EAST;
      b1_v    <= 1'b0;
      b2_v    <= 1'b0;
      b3_v    <= 1'b0;
      b4_v    <= 1'b0;
    end else begin
      if (issue) dir_cnt <= (dir_cnt == DIR_REST) ? DIR_EAST : dir_cnt + 4'd1;
      if (adv) begin
        b1_v <= q_valid;
        b2_v <= b1_v;
        b3_v <= b2_v;
        b4_v <= b3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_dir <= dir_cnt;
      b2_dir <= b1_dir;
      b3_dir <= b2_dir;
      b4_dir <= b3_dir;
      for (int l = 0; l < LANES; l++) begin
        b1_x[l] <= sel_x[l];
        b1_s[l] <= sel_s[l];
        b1_u[l] <= lane[l].u15;
        b2_a[l] <= (b1_dir == DIR_REST) ? prod[l] : qimul(b1_x[l], 4'sd3);
        b2_b[l] <= (b1_dir == DIR_REST) ? '0 : prod[l];
        b2_u[l] <= b1_u[l];
        b3_t[l] <= qsub(qadd(b2_a[l], b2_b[l]), b2_u[l]);
        b4_y[l] <= qmul(scale, b3_t[l]);
      end
    end
  end

  assign result.valid          = b4_v;
  assign result.direction      = b4_dir;
  assign result.eq_order_param = b4_y[0];
  assign result.eq_density     = b4_y[1];
  assign result.last_of_node   = b4_dir == DIR_REST;

  `BFLBM_ASSERT_NEXT(a_dir_step, issue && dir_cnt != DIR_REST, dir_cnt == 4'($past(dir_cnt) + 4'd1), "direction counter skipped")
  `BFLBM_ASSERT_NEXT(a_dir_wrap, issue && dir_cnt == DIR_REST, dir_cnt == DIR_EAST, "direction counter did not wrap")
  `BFLBM_ASSERT_IMPL(a_pop_last, q_valid && q_ready, dir_cnt == DIR_REST && issue, "node popped before rest direction")

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bflbm_pkg::*;

  typedef struct {
    q_t c, n, s, e, w, ne, nw, sw, se, r, ux, uy;
  } node_req_t;

  typedef struct {
    dir_t dir;
    q_t   phi_eq;
    q_t   rho_eq;
    logic last;
  } eq_result_t;

  class equilibrium_board;
    q_t a, b, kap;
    eq_result_t pending[$];
    int errors;
    int nodes_seen;
    int results_seen;

    function void reset_coeffs();
      a = COEFF_A_RESET;
      b = COEFF_B_RESET;
      kap = KAPPA_RESET;
    endfunction

    function void write_coeff(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
      if (idx == 0) a = v;
      else if (idx == 1) b = v;
      else if (idx == 2) kap = v;
    endfunction

    function q_t clamp(longint v);
      if (v > 64'sh7FFF_FFFF) return Q_MAX;
      if (v < -64'sh8000_0000) return Q_MIN;
      return q_t'(v);
    endfunction

    function q_t add(q_t x, q_t y);
      return clamp(longint'(x) + longint'(y));
    endfunction

    function q_t sub(q_t x, q_t y);
      return clamp(longint'(x) - longint'(y));
    endfunction

    function q_t neg(q_t x);
      return clamp(-longint'(x));
    endfunction

    function q_t times(q_t x, int k);
      return clamp(longint'(x) * k);
    endfunction

    function q_t fmul(q_t x, q_t y);
      longint p;
      p = longint'(x) * longint'(y) + (longint'(1) << (FRAC_BITS - 1));
      return clamp(p >>> FRAC_BITS);
    endfunction

    function q_t moving(q_t scale, q_t v, q_t s, q_t usq);
      q_t t;
      t = add(times(v, 3), fmul(K_9_2, s));
      t = sub(t, fmul(K_3_2, usq));
      return fmul(scale, t);
    endfunction

    function void field_eq(q_t m, q_t ux, q_t uy, q_t exx, q_t eyy, q_t exy,
                           output q_t f[9]);
      q_t mx, my, sxx, syy, sxy, usq, dp, dm;
      mx = fmul(m, ux);
      my = fmul(m, uy);
      sxx = add(fmul(mx, ux), exx);
      syy = add(fmul(my, uy), eyy);
      sxy = add(times(fmul(mx, uy), 2), exy);
      usq = add(sxx, syy);
      dp = add(add(sxx, sxy), syy);
      dm = add(sub(sxx, sxy), syy);
      f[0] = moving(K_1_9, mx, sxx, usq);
      f[1] = moving(K_1_9, my, syy, usq);
      f[2] = moving(K_1_9, neg(mx), sxx, usq);
      f[3] = moving(K_1_9, neg(my), syy, usq);
      f[4] = moving(K_1_36, add(mx, my), dp, usq);
      f[5] = moving(K_1_36, sub(my, mx), dm, usq);
      f[6] = moving(K_1_36, sub(neg(mx), my), dp, usq);
      f[7] = moving(K_1_36, sub(mx, my), dm, usq);
      f[8] = fmul(K_4_9, sub(fmul(K_9_4, m), fmul(K_3_2, usq)));
    endfunction

    function void note_node(node_req_t x);
      q_t t, gx, gy, lap, p2, pi, pxx, pyy, pxy, mu, gx2, gy2, kgx;
      q_t fphi[9], frho[9];
      eq_result_t res;
      t = add(sub(sub(x.ne, x.sw), x.nw), x.se);
      gx = fmul(K_1_12, add(t, times(sub(x.e, x.w), 4)));
      t = sub(add(sub(x.ne, x.sw), x.nw), x.se);
      gy = fmul(K_1_12, add(t, times(sub(x.n, x.s), 4)));
      t = sub(add(add(add(x.s, x.n), x.w), x.e), times(x.c, 5));
      t = add(add(add(add(x.sw, x.ne), x.nw), x.se), times(t, 4));
      lap = fmul(K_1_6, t);
      p2 = fmul(x.c, x.c);
      gx2 = fmul(gx, gx);
      gy2 = fmul(gy, gy);
      pi = add(fmul(K_1_2, fmul(a, p2)), fmul(K_3_4, fmul(b, fmul(p2, p2))));
      t = add(fmul(x.c, lap), fmul(K_1_2, add(gx2, gy2)));
      pi = sub(pi, fmul(kap, t));
      pi = add(pi, fmul(x.r, K_1_3));
      kgx = fmul(kap, gx);
      pxx = add(pi, fmul(kgx, gx));
      pyy = add(pi, fmul(fmul(kap, gy), gy));
      pxy = fmul(kgx, gy);
      t = sub(add(fmul(a, x.c), fmul(b, fmul(p2, x.c))), fmul(kap, lap));
      mu = fmul(x.r, t);
      field_eq(x.c, x.ux, x.uy, mu, mu, '0, fphi);
      field_eq(x.r, x.ux, x.uy, pxx, pyy, times(pxy, 2), frho);
      for (int k = 0; k < 9; k++) begin
        res.dir = dir_t'(k);
        res.phi_eq = fphi[k];
        res.rho_eq = frho[k];
        res.last = (k == 8);
        pending.push_back(res);
      end
      nodes_seen++;
    endfunction

    function void check_result(dir_t dir, q_t phi_eq, q_t rho_eq, logic last);
      eq_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result: direction %0d", dir);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (dir !== want.dir) begin
        $error("direction: expected %0d, got %0d", want.dir, dir);
        errors++;
      end
      if (phi_eq !== want.phi_eq) begin
        $error("eq_order_param: expected %0d, got %0d", want.phi_eq, phi_eq);
        errors++;
      end
      if (rho_eq !== want.rho_eq) begin
        $error("eq_density: expected %0d, got %0d", want.rho_eq, rho_eq);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_node: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;

  bflbm_node_if node ();
  bflbm_result_if result ();

  binary_fluid_lbm_equilibrium dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .node(node.sink), .result(result.source)
  );

  equilibrium_board board = new();

  always #2 clk = ~clk;

  initial begin
    node.valid = 0;
    node.phi_center = 0; node.phi_north = 0; node.phi_south = 0;
    node.phi_east = 0; node.phi_west = 0; node.phi_northeast = 0;
    node.phi_northwest = 0; node.phi_southwest = 0; node.phi_southeast = 0;
    node.density = 0; node.velocity_x = 0; node.velocity_y = 0;
    result.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else begin
      if (result.valid && result.ready)
        board.check_result(result.direction, result.eq_order_param,
                           result.eq_density, result.last_of_node);
      result.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_node(node_req_t x);
    while ($urandom_range(99) < send_idle) begin
      node.valid <= 0;
      @(posedge clk);
    end
    node.valid <= 1;
    node.phi_center <= x.c; node.phi_north <= x.n; node.phi_south <= x.s;
    node.phi_east <= x.e; node.phi_west <= x.w; node.phi_northeast <= x.ne;
    node.phi_northwest <= x.nw; node.phi_southwest <= x.sw;
    node.phi_southeast <= x.se; node.density <= x.r;
    node.velocity_x <= x.ux; node.velocity_y <= x.uy;
    do @(posedge clk); while (!node.ready);
    board.note_node(x);
  endtask

  task automatic write_coeff(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    board.write_coeff(idx, v);
  endtask

  task automatic drain();
    node.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic q_t pick(bit wide);
    if (wide) return q_t'($urandom);
    return q_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
  endfunction

  function automatic node_req_t rand_node(bit wide);
    node_req_t x;
    x.c = pick(wide); x.n = pick(wide); x.s = pick(wide); x.e = pick(wide);
    x.w = pick(wide); x.ne = pick(wide); x.nw = pick(wide); x.sw = pick(wide);
    x.se = pick(wide); x.r = pick(wide); x.ux = pick(wide); x.uy = pick(wide);
    x.r = wide ? x.r : q_t'($urandom_range(32'h0080_0000, 32'h0200_0000));
    x.ux = wide ? x.ux : q_t'(int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000);
    x.uy = wide ? x.uy : q_t'(int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000);
    return x;
  endfunction

  function automatic node_req_t flat_node(q_t v, q_t r, q_t u);
    node_req_t x;
    x = '{v, v, v, v, v, v, v, v, v, r, u, u};
    return x;
  endfunction

  task automatic directed_nodes();
    node_req_t x;
    send_node(flat_node(0, 0, 0));
    send_node(flat_node(Q_MAX, Q_MAX, Q_MAX));
    send_node(flat_node(Q_MIN, Q_MIN, Q_MIN));
    send_node(flat_node(32'sh0100_0000, 32'sh0100_0000, 32'sh0019_999A));
    send_node(flat_node(32'shFF00_0000, 32'sh0100_0000, 32'shFFE6_6666));
    // sharp interface: center high, ring low
    x = flat_node(Q_MIN, 32'sh0100_0000, 0);
    x.c = Q_MAX;
    send_node(x);
    x = flat_node(32'sh0100_0000, 32'sh0100_0000, 32'sh0010_0000);
    x.e = Q_MAX; x.w = Q_MIN; x.n = Q_MIN; x.s = Q_MAX;
    send_node(x);
    x.ne = Q_MAX; x.sw = Q_MIN; x.nw = Q_MAX; x.se = Q_MIN;
    send_node(x);
    x = flat_node(32'shFF00_0000, Q_MIN, Q_MAX);
    x.uy = Q_MIN;
    send_node(x);
    send_node(flat_node(-32'sh1, 32'sh1, -32'sh1));
    for (int i = 0; i < 4; i++) send_node(rand_node(1));
  endtask

  task automatic random_nodes(int count);
    for (int i = 0; i < count; i++) send_node(rand_node($urandom_range(4) == 0));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    board.reset_coeffs();
    @(posedge clk);
    directed_nodes();
    random_nodes(30);
    drain();

    send_idle = 47;
    write_coeff(0, 32'h7FFF_FFFF);
    write_coeff(1, 32'h7FFF_FFFF);
    write_coeff(2, 32'h7FFF_FFFF);
    write_coeff(3, 32'h0);
    random_nodes(30);
    drain();

    send_idle = 0;
    recv_stall = 47;
    write_coeff(0, 32'h8000_0000);
    write_coeff(1, 32'h8000_0000);
    write_coeff(2, 32'h8000_0000);
    random_nodes(30);
    drain();

    send_idle = 33;
    recv_stall = 33;
    write_coeff(0, $urandom);
    write_coeff(1, $urandom);
    write_coeff(2, $urandom);
    write_coeff(3, $urandom);
    random_nodes(30);
    drain();

    send_idle = 0;
    recv_stall = 0;
    write_coeff(0, 32'hFFE6_6666);
    write_coeff(1, 32'h0019_999A);
    write_coeff(2, 32'h0000_0000);
    random_nodes(30);
    drain();

    $display("covered %0d nodes and %0d direction results over five coefficient sets",
             board.nodes_seen, board.results_seen);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
